// ===== hdl/dcc_pkg.sv =====
// ----------------------------------------------------------------------------
// dcc_pkg: shared constants for the disciplined clock corrector
// Field widths, opcodes, register indexes, register reset values and the
// default values of the top level parameters.
// ----------------------------------------------------------------------------
package dcc_pkg;

   // default parameter values
   localparam int FREQ_FRAC_BITS_DEF  = 30;
   localparam int PHASE_FRAC_BITS_DEF = 16;
   localparam int TIME_BITS_DEF       = 32;
   localparam int DIV_STEPS_DEF       = 2;    // quotient bits resolved per cycle

   // field and datapath widths
   localparam int FIELD_W     = 32;
   localparam int OPCODE_W    = 3;
   localparam int REG_W       = 31;
   localparam int REG_COUNT   = 6;
   localparam int REG_INDEX_W = 3;
   localparam int RATE_W      = 32;
   localparam int ACC_W       = 64;
   localparam int MUL_A_W     = 33;
   localparam int MUL_B_W     = 32;
   localparam int PROD_W      = 64;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_INIT    = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_READ    = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_UNTIL   = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_PHASE   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_CORRECT = 3'd4;

   // register indexes
   localparam logic [REG_INDEX_W-1:0] REG_FW_START  = 3'd0;
   localparam logic [REG_INDEX_W-1:0] REG_FW_STEP   = 3'd1;
   localparam logic [REG_INDEX_W-1:0] REG_FW_TARGET = 3'd2;
   localparam logic [REG_INDEX_W-1:0] REG_PW_START  = 3'd3;
   localparam logic [REG_INDEX_W-1:0] REG_PW_STEP   = 3'd4;
   localparam logic [REG_INDEX_W-1:0] REG_PW_TARGET = 3'd5;

   // register reset values
   localparam logic [REG_W-1:0] FW_START_RST  = 31'd536870912;
   localparam logic [REG_W-1:0] FW_STEP_RST   = 31'd5368709;
   localparam logic [REG_W-1:0] FW_TARGET_RST = 31'd10737418;
   localparam logic [REG_W-1:0] PW_START_RST  = 31'd32768;
   localparam logic [REG_W-1:0] PW_STEP_RST   = 31'd327;
   localparam logic [REG_W-1:0] PW_TARGET_RST = 31'd655;

endpackage

// ===== hdl/disciplined_clock_corrector_top.sv =====
// ----------------------------------------------------------------------------
// disciplined_clock_corrector_top: disciplined time from a raw tick counter
// Keeps an offset, a frequency rate and a fractional phase accumulator and
// answers time reads, wait-tick queries and phase/frequency corrections.
// ----------------------------------------------------------------------------
//
//   port group | dir  | contents
//   -----------+------+---------------------------------------------------
//   req_*      | in   | request: opcode in tuser, raw/target/correction data
//   rsp_*      | out  | one result per request: result_value
//   csr_*      | in   | write-only register port, six 31-bit registers
//
// One request at a time; req_tready is high only while the sequencer idles.
// A ticks-until query for a target at or before the corrected time skips the
// remaining wait states; add correction skips the divider with no elapsed
// ticks and otherwise waits on the serial divider (64-bit dividend, two
// quotient bits a cycle).
// A waiting result sits in the response register; a stalled response holds
// the sequencer in its final state. Synchronous active-high reset; no
// clearing pass.
//
module disciplined_clock_corrector_top #(
   parameter int FREQ_FRAC_BITS  = dcc_pkg::FREQ_FRAC_BITS_DEF,
   parameter int PHASE_FRAC_BITS = dcc_pkg::PHASE_FRAC_BITS_DEF,
   parameter int TIME_BITS       = dcc_pkg::TIME_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [3*dcc_pkg::FIELD_W-1:0]       req_tdata,  // raw sample, wait target, correction
   input  logic [dcc_pkg::OPCODE_W-1:0]        req_tuser,  // opcode
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dcc_pkg::FIELD_W-1:0]         rsp_tdata,  // result_value
   // register write port
   input  logic                                csr_we,
   input  logic [dcc_pkg::REG_INDEX_W-1:0]     csr_index,
   input  logic [dcc_pkg::REG_W-1:0]           csr_wdata
);

   localparam int TB     = TIME_BITS;
   localparam int FW     = dcc_pkg::FIELD_W;
   localparam int ACC_W  = dcc_pkg::ACC_W;
   localparam int REG_W  = dcc_pkg::REG_W;
   localparam int IDX_W  = dcc_pkg::REG_INDEX_W;
   localparam logic [ACC_W-1:0] FRAC_MASK = (ACC_W'(1) << PHASE_FRAC_BITS) - ACC_W'(1);

   // sequencer states
   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_PH1     = 4'd2;
   localparam logic [3:0] S_PH2     = 4'd3;
   localparam logic [3:0] S_PH3     = 4'd4;
   localparam logic [3:0] S_TU0     = 4'd5;
   localparam logic [3:0] S_TU1     = 4'd6;
   localparam logic [3:0] S_TU2     = 4'd7;
   localparam logic [3:0] S_CFREQ   = 4'd8;
   localparam logic [3:0] S_CDIVSET = 4'd9;
   localparam logic [3:0] S_CPHASE  = 4'd10;
   localparam logic [3:0] S_CDIV    = 4'd11;
   localparam logic [3:0] S_DONE    = 4'd12;

   // registers
   logic [REG_W-1:0]            cfg_ff [dcc_pkg::REG_COUNT];
   logic [3:0]                  state_ff, state_in;
   logic [dcc_pkg::OPCODE_W-1:0] op_ff, op_in;
   logic [TB-1:0]               raw_ff, raw_in;
   logic [TB-1:0]               target_ff, target_in;
   logic [FW-1:0]               corr_ff, corr_in;
   logic [TB-1:0]               lur_ff, lur_in;        // raw time of last update
   logic [TB-1:0]               lc_ff, lc_in;          // last corrected time
   logic [TB-1:0]               off_ff, off_in;        // time offset
   logic [dcc_pkg::RATE_W-1:0]  rate_ff, rate_in;      // signed frequency rate
   logic [ACC_W-1:0]            acc_ff, acc_in;        // signed phase accumulator
   logic [REG_W-1:0]            fw_ff, fw_in;
   logic [REG_W-1:0]            pw_ff, pw_in;
   logic [TB-1:0]               since_ff, since_in;
   logic [TB-1:0]               fc_ff, fc_in;
   logic [TB-1:0]               elapsed_ff, elapsed_in;
   logic [TB-1:0]               delta_ff, delta_in;
   logic [TB-1:0]               res_ff, res_in;
   logic                        neg_ff, neg_in;
   logic [dcc_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [FW-1:0]               rsp_data_ff, rsp_data_in;

   // shared multiplier
   logic signed [dcc_pkg::MUL_A_W-1:0]                    mul_a;
   logic signed [dcc_pkg::MUL_B_W-1:0]                    mul_b;
   logic signed [dcc_pkg::MUL_A_W+dcc_pkg::MUL_B_W-1:0]   mul_p;

   // combinational helpers
   logic [TB-1:0]    since_w;
   logic [TB-1:0]    fterm_w;
   logic [TB-1:0]    delta_w;
   logic [ACC_W-1:0] acc_shr;
   logic [ACC_W-1:0] pc_neg;
   logic [ACC_W-1:0] elapsed_ext;
   logic [ACC_W-1:0] pc_read;
   logic [ACC_W-1:0] d2_ext;
   logic [ACC_W-1:0] pc_until;
   logic             acc_pos;
   logic             acc_neg;
   logic [REG_W-1:0] fw_dec, fw_new, pw_dec, pw_new;
   logic [ACC_W-1:0] mag;
   logic [dcc_pkg::RATE_W-1:0] q_low;
   logic             div_start;
   logic             div_busy;
   logic [ACC_W-1:0] div_quot;
   logic             rsp_free;

   // request fields
   logic [TB-1:0]    req_raw;
   logic [TB-1:0]    req_target;
   logic [FW-1:0]    req_corr;

   assign req_raw    = req_tdata[TB-1:0];
   assign req_target = req_tdata[FW +: TB];
   assign req_corr   = req_tdata[2*FW +: FW];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // register file: written any time the port strobes, ignore unused indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[dcc_pkg::REG_FW_START]  <= dcc_pkg::FW_START_RST;
         cfg_ff[dcc_pkg::REG_FW_STEP]   <= dcc_pkg::FW_STEP_RST;
         cfg_ff[dcc_pkg::REG_FW_TARGET] <= dcc_pkg::FW_TARGET_RST;
         cfg_ff[dcc_pkg::REG_PW_START]  <= dcc_pkg::PW_START_RST;
         cfg_ff[dcc_pkg::REG_PW_STEP]   <= dcc_pkg::PW_STEP_RST;
         cfg_ff[dcc_pkg::REG_PW_TARGET] <= dcc_pkg::PW_TARGET_RST;
      end else if (csr_we && (csr_index < IDX_W'(dcc_pkg::REG_COUNT))) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   // elapsed raw ticks and the frequency term pulled out of the product
   assign since_w = raw_ff - lur_ff;
   assign fterm_w = prod_ff[FREQ_FRAC_BITS +: TB];
   assign delta_w = target_ff - lc_ff;

   // phase accumulator: whole ticks pending, positive or negative
   assign acc_shr     = $signed(acc_ff) >>> PHASE_FRAC_BITS;
   assign acc_neg     = acc_ff[ACC_W-1];
   assign acc_pos     = !acc_ff[ACC_W-1] && (acc_ff != '0);
   assign pc_neg      = ~acc_shr;
   assign elapsed_ext = {{(ACC_W-TB){1'b0}}, elapsed_ff};
   // never step back further than the corrected time that has passed
   assign pc_read     = (elapsed_ext < pc_neg) ? elapsed_ext : pc_neg;

   // wait ticks: pending negative phase is limited to the signed delta
   assign d2_ext = {{(ACC_W-TB){delta_ff[TB-1]}}, delta_ff};
   always_comb begin
      pc_until = '0;
      if (acc_pos) begin
         pc_until = acc_shr;
      end else if (acc_neg) begin
         pc_until = ($signed(d2_ext) < $signed(pc_neg)) ? d2_ext : pc_neg;
      end
   end

   // weight stepping: subtract only when above the step, then clamp at target
   assign fw_dec = (fw_ff > cfg_ff[dcc_pkg::REG_FW_STEP]) ?
                   fw_ff - cfg_ff[dcc_pkg::REG_FW_STEP] : fw_ff;
   assign fw_new = (fw_dec < cfg_ff[dcc_pkg::REG_FW_TARGET]) ?
                   cfg_ff[dcc_pkg::REG_FW_TARGET] : fw_dec;
   assign pw_dec = (pw_ff > cfg_ff[dcc_pkg::REG_PW_STEP]) ?
                   pw_ff - cfg_ff[dcc_pkg::REG_PW_STEP] : pw_ff;
   assign pw_new = (pw_dec < cfg_ff[dcc_pkg::REG_PW_TARGET]) ?
                   cfg_ff[dcc_pkg::REG_PW_TARGET] : pw_dec;

   // magnitude of correction * frequency weight for the divider
   assign mag   = prod_ff[ACC_W-1] ? (ACC_W'(0) - prod_ff) : prod_ff;
   assign q_low = div_quot[dcc_pkg::RATE_W-1:0];

   // operand select for the shared multiplier; product registered every cycle
   always_comb begin
      mul_a = $signed({{(dcc_pkg::MUL_A_W-TB){1'b0}}, since_w});
      mul_b = $signed(rate_ff);
      case (state_ff)
         S_TU0: begin
            mul_a = $signed({{(dcc_pkg::MUL_A_W-TB){1'b0}}, delta_w});
            mul_b = $signed(rate_ff);
         end
         S_CFREQ: begin
            mul_a = $signed({corr_ff[FW-1], corr_ff});
            mul_b = $signed({1'b0, fw_ff});
         end
         S_CDIVSET: begin
            mul_a = $signed({corr_ff[FW-1], corr_ff});
            mul_b = $signed({1'b0, pw_ff});
         end
         default: begin
            mul_a = $signed({{(dcc_pkg::MUL_A_W-TB){1'b0}}, since_w});
            mul_b = $signed(rate_ff);
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign prod_in = mul_p[dcc_pkg::PROD_W-1:0];

   assign div_start = (state_ff == S_CDIVSET);

   dcc_div #(
      .DIVIDEND_W (ACC_W),
      .DIVISOR_W  (TB),
      .STEPS      (dcc_pkg::DIV_STEPS_DEF)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag),
      .divisor  (since_ff),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      raw_in       = raw_ff;
      target_in    = target_ff;
      corr_in      = corr_ff;
      lur_in       = lur_ff;
      lc_in        = lc_ff;
      off_in       = off_ff;
      rate_in      = rate_ff;
      acc_in       = acc_ff;
      fw_in        = fw_ff;
      pw_in        = pw_ff;
      since_in     = since_ff;
      fc_in        = fc_ff;
      elapsed_in   = elapsed_ff;
      delta_in     = delta_ff;
      res_in       = res_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // drop the response once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser;
               raw_in    = req_raw;
               target_in = req_target;
               corr_in   = req_corr;
               state_in  = S_DECODE;
            end
         end

         S_DECODE: begin
            res_in = '0;
            case (op_ff)
               dcc_pkg::OP_INIT: begin
                  lur_in   = raw_ff;
                  lc_in    = raw_ff;
                  off_in   = '0;
                  rate_in  = '0;
                  acc_in   = '0;
                  fw_in    = cfg_ff[dcc_pkg::REG_FW_START];
                  pw_in    = cfg_ff[dcc_pkg::REG_PW_START];
                  state_in = S_DONE;
               end
               dcc_pkg::OP_READ, dcc_pkg::OP_UNTIL: begin
                  state_in = S_PH1;
               end
               dcc_pkg::OP_PHASE: begin
                  // apply the phase step now and forget pending fractions
                  off_in   = off_ff + corr_ff[TB-1:0];
                  acc_in   = '0;
                  state_in = S_PH1;
               end
               dcc_pkg::OP_CORRECT: begin
                  lur_in   = raw_ff;
                  since_in = since_w;
                  state_in = (since_w == '0) ? S_DONE : S_CFREQ;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         // read time: hold the frequency term, measure corrected time passed
         S_PH1: begin
            fc_in      = fterm_w;
            elapsed_in = raw_ff + off_ff + fterm_w - lc_ff;
            state_in   = S_PH2;
         end

         // fold whole phase ticks into the offset
         S_PH2: begin
            if (acc_pos) begin
               off_in = off_ff + acc_shr[TB-1:0];
               acc_in = acc_ff & FRAC_MASK;
            end else if (acc_neg) begin
               off_in = off_ff - pc_read[TB-1:0];
               acc_in = acc_ff + (pc_read << PHASE_FRAC_BITS);
            end
            state_in = S_PH3;
         end

         S_PH3: begin
            lc_in  = raw_ff + off_ff + fc_ff;
            res_in = raw_ff + off_ff + fc_ff;
            if (op_ff == dcc_pkg::OP_UNTIL) begin
               state_in = S_TU0;
            end else begin
               if (op_ff == dcc_pkg::OP_PHASE) begin
                  lur_in = raw_ff;
               end
               state_in = S_DONE;
            end
         end

         // ticks until target: a target at or before the last corrected time gives zero
         S_TU0: begin
            if (delta_w[TB-1] || (delta_w == '0)) begin
               res_in   = '0;
               state_in = S_DONE;
            end else begin
               delta_in = delta_w;
               state_in = S_TU1;
            end
         end

         S_TU1: begin
            delta_in = delta_ff + fterm_w;
            state_in = S_TU2;
         end

         S_TU2: begin
            res_in   = d2_ext[TB-1:0] + pc_until[TB-1:0];
            state_in = S_DONE;
         end

         // add correction: fold drift since last update into the offset
         S_CFREQ: begin
            off_in   = off_ff + fterm_w;
            state_in = S_CDIVSET;
         end

         S_CDIVSET: begin
            neg_in   = prod_ff[dcc_pkg::PROD_W-1];
            state_in = S_CPHASE;
         end

         S_CPHASE: begin
            acc_in   = acc_ff + prod_ff;
            state_in = S_CDIV;
         end

         S_CDIV: begin
            if (!div_busy) begin
               rate_in  = neg_ff ? rate_ff - q_low : rate_ff + q_low;
               fw_in    = fw_new;
               pw_in    = pw_new;
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(FW-TB){1'b0}}, res_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         lur_ff       <= '0;
         lc_ff        <= '0;
         off_ff       <= '0;
         rate_ff      <= '0;
         acc_ff       <= '0;
         fw_ff        <= dcc_pkg::FW_START_RST;
         pw_ff        <= dcc_pkg::PW_START_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lur_ff       <= lur_in;
         lc_ff        <= lc_in;
         off_ff       <= off_in;
         rate_ff      <= rate_in;
         acc_ff       <= acc_in;
         fw_ff        <= fw_in;
         pw_ff        <= pw_in;
      end
      op_ff       <= op_in;
      raw_ff      <= raw_in;
      target_ff   <= target_in;
      corr_ff     <= corr_in;
      since_ff    <= since_in;
      fc_ff       <= fc_in;
      elapsed_ff  <= elapsed_in;
      delta_ff    <= delta_in;
      res_ff      <= res_in;
      neg_ff      <= neg_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/dcc_div.sv =====
// ----------------------------------------------------------------------------
// dcc_div: iterative unsigned divider
// Restoring division, STEPS quotient bits per cycle. Quotient is valid once
// busy drops after a start pulse.
// ----------------------------------------------------------------------------
module dcc_div #(
   parameter int DIVIDEND_W = dcc_pkg::ACC_W,
   parameter int DIVISOR_W  = dcc_pkg::TIME_BITS_DEF,
   parameter int STEPS      = dcc_pkg::DIV_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CYCLES = DIVIDEND_W / STEPS;
   localparam int CNT_W  = $clog2(CYCLES + 1);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [DIVIDEND_W-1:0] num_ff, num_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic [DIVIDEND_W-1:0] num_step;
   logic [DIVISOR_W-1:0]  rem_step;

   // shift-subtract steps; the quotient shifts into the dividend register
   always_comb begin
      logic [DIVISOR_W:0] rem_sh;
      num_step = num_ff;
      rem_step = rem_ff;
      for (int i = 0; i < STEPS; i++) begin
         rem_sh   = {rem_step, num_step[DIVIDEND_W-1]};
         num_step = {num_step[DIVIDEND_W-2:0], 1'b0};
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_sh      = rem_sh - {1'b0, den_ff};
            num_step[0] = 1'b1;
         end
         rem_step = rem_sh[DIVISOR_W-1:0];
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_W'(CYCLES - 1);
         num_in   = dividend;
         rem_in   = '0;
         den_in   = divisor;
      end else if (busy_ff) begin
         num_in = num_step;
         rem_in = rem_step;
         if (count_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign quotient = num_ff;

endmodule
